### rtl/sbl_pkg.sv
`default_nettype none

package sbl_pkg;

   // Field and register widths.
   localparam int PIXEL_W      = 8;
   localparam int GRAD_W       = 11;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   // Reset values of the configuration registers.
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1024;

   // Register indexes (word address bit 2).
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // One input word causes at most this many result words.
   localparam int MAX_RUN   = 4;
   localparam int RUN_CNT_W = 3;

   // Result queue geometry.
   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W       = 3;
   localparam int LEVEL_W     = 4;

   // The 3x3 window, indexed [row][column], row 0 on top, column 0 on the left.
   typedef logic [2:0][2:0][PIXEL_W-1:0] window_type;

   // One result word.
   typedef struct packed {
      logic signed [GRAD_W-1:0] grad_x;
      logic signed [GRAD_W-1:0] grad_y;
      logic                     last_of_run;
      logic                     frame_end;
   } rsp_entry_type;

   // The result words that one input word pushes into the queue, packed from entry 0.
   typedef struct packed {
      logic [RUN_CNT_W-1:0]         count;
      rsp_entry_type [MAX_RUN-1:0]  entry;
   } rsp_push_type;

   // Position flags worked out when a pixel is accepted.
   typedef struct packed {
      logic top_row;
      logic left_col;
      logic has_result;
      logic row_end;
      logic last_row;
   } step_flags_type;

   // Sobel gradients over window rows t, m, b and columns l, c, r.
   function automatic rsp_entry_type sobel_at(window_type win,
                                              logic [1:0] t, logic [1:0] m, logic [1:0] b,
                                              logic [1:0] l, logic [1:0] c, logic [1:0] r,
                                              logic fend);
      logic [GRAD_W-1:0] right_sum;
      logic [GRAD_W-1:0] left_sum;
      logic [GRAD_W-1:0] bottom_sum;
      logic [GRAD_W-1:0] top_sum;
      rsp_entry_type     result;
      right_sum  = {3'b000, win[t][r]} + {2'b00, win[m][r], 1'b0} + {3'b000, win[b][r]};
      left_sum   = {3'b000, win[t][l]} + {2'b00, win[m][l], 1'b0} + {3'b000, win[b][l]};
      bottom_sum = {3'b000, win[b][l]} + {2'b00, win[b][c], 1'b0} + {3'b000, win[b][r]};
      top_sum    = {3'b000, win[t][l]} + {2'b00, win[t][c], 1'b0} + {3'b000, win[t][r]};
      result.grad_x      = right_sum - left_sum;
      result.grad_y      = bottom_sum - top_sum;
      result.last_of_run = 1'b0;
      result.frame_end   = fend;
      return result;
   endfunction

endpackage

`default_nettype wire

### rtl/sobel_gradient_3x3_unit.sv
// A result word passes the input stage register and then the result queue before it is taken.
// Throughput: one pixel per cycle; an output queue of eight words absorbs the row-end
// and last-row extra words, and input stalls only when that queue cannot take four more.
// Reset is synchronous: counters, window, queue and pipeline clear, width and height
// return to 1024; the two line stores are not cleared and hold garbage until written.
`default_nettype none

module sobel_gradient_3x3_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [sbl_pkg::PIXEL_W-1:0]        req_pixel_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [sbl_pkg::GRAD_W-1:0]       rsp_grad_x,
   output logic signed [sbl_pkg::GRAD_W-1:0]       rsp_grad_y,
   output logic                                    rsp_last_of_run,
   output logic                                    rsp_frame_end,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [sbl_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [sbl_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sbl_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                    csr_pready
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [sbl_pkg::WIDTH_REG_W-1:0]  width_ff;
   logic [sbl_pkg::HEIGHT_REG_W-1:0] height_ff;
   logic                             csr_write;
   logic                             csr_index;

   logic [COL_W-1:0]                 last_col;
   logic [sbl_pkg::HEIGHT_REG_W-1:0] last_row;
   logic [COL_W-1:0]                 col_ff, col_in, col_cur;
   logic [sbl_pkg::HEIGHT_REG_W-1:0] row_ff, row_in, row_cur;
   logic                             req_accept;
   sbl_pkg::step_flags_type          flags_cur;

   logic                             s1_valid_ff;
   logic [sbl_pkg::PIXEL_W-1:0]      s1_pixel_ff;
   logic [COL_W-1:0]                 s1_col_ff;
   sbl_pkg::step_flags_type          s1_flags_ff;

   logic [sbl_pkg::PIXEL_W-1:0]      above_rd_data;
   logic [sbl_pkg::PIXEL_W-1:0]      two_above_rd_data;

   sbl_pkg::window_type              window_ff, window_in, window_next;
   sbl_pkg::rsp_entry_type           res_main, res_flush, res_last_main, res_last_flush;
   sbl_pkg::rsp_push_type            push;
   sbl_pkg::rsp_entry_type           head;
   logic                             rsp_pop;
   logic [sbl_pkg::LEVEL_W-1:0]      queue_level;

   // Configuration port: always ready, word index in address bit 2.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sbl_pkg::WIDTH_RESET;
         height_ff <= sbl_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            sbl_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[sbl_pkg::WIDTH_REG_W-1:0];
            sbl_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[sbl_pkg::HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         sbl_pkg::REG_IMAGE_WIDTH:
            csr_prdata = {{(sbl_pkg::CSR_DATA_W - sbl_pkg::WIDTH_REG_W){1'b0}}, width_ff};
         sbl_pkg::REG_IMAGE_HEIGHT:
            csr_prdata = {{(sbl_pkg::CSR_DATA_W - sbl_pkg::HEIGHT_REG_W){1'b0}}, height_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   // Last column and last row after clamping the registers.
   always_comb begin
      priority if (width_ff < 11'd2) begin
         last_col = COL_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         last_col = COL_W'(MAX_WIDTH - 1);
      end else begin
         last_col = COL_W'(width_ff - 11'd1);
      end
      if (height_ff < 13'd2) begin
         last_row = 13'd1;
      end else begin
         last_row = height_ff - 13'd1;
      end
   end

   // Position of the pixel being accepted and what it releases.
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      col_cur = (col_ff > last_col) ? '0 : col_ff;
      row_cur = (row_ff > last_row) ? '0 : row_ff;
      flags_cur.top_row    = (row_cur == 13'd1);
      flags_cur.left_col   = (col_cur == COL_W'(1));
      flags_cur.has_result = (row_cur != '0) && (col_cur != '0);
      flags_cur.row_end    = (col_cur == last_col);
      flags_cur.last_row   = (row_cur == last_row);
   end

   // Raster counters; any register write restarts the frame.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (csr_write) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (col_cur == last_col) begin
            col_in = '0;
            row_in = (row_cur == last_row) ? '0 : row_cur + 13'd1;
         end else begin
            col_in = col_cur + COL_W'(1);
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Input stage register; line store reads are issued at the same edge.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= req_pixel_value;
         s1_col_ff   <= col_cur;
         s1_flags_ff <= flags_cur;
      end
   end

   // Line stores: the row above moves down, the new pixel becomes the row above.
   sbl_ram #(
      .WIDTH (sbl_pkg::PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_above (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pixel_ff),
      .rd_en   (req_accept),
      .rd_addr (col_cur),
      .rd_data (above_rd_data)
   );

   sbl_ram #(
      .WIDTH (sbl_pkg::PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_two_above (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (above_rd_data),
      .rd_en   (req_accept),
      .rd_addr (col_cur),
      .rd_data (two_above_rd_data)
   );

   // Window shift: columns move left, the new column enters on the right.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         window_next[i][0] = window_ff[i][1];
         window_next[i][1] = window_ff[i][2];
      end
      window_next[0][2] = two_above_rd_data;
      window_next[1][2] = above_rd_data;
      window_next[2][2] = s1_pixel_ff;
      window_in = s1_valid_ff ? window_next : window_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   // Gradients: the pixel one row up, then the row-end flush, then the last-row pair.
   always_comb begin
      res_main = sbl_pkg::sobel_at(window_next,
                                   s1_flags_ff.top_row ? 2'd1 : 2'd0, 2'd1, 2'd2,
                                   s1_flags_ff.left_col ? 2'd1 : 2'd0, 2'd1, 2'd2, 1'b0);
      res_flush = sbl_pkg::sobel_at(window_next,
                                    s1_flags_ff.top_row ? 2'd1 : 2'd0, 2'd1, 2'd2,
                                    2'd1, 2'd2, 2'd2, 1'b0);
      res_last_main = sbl_pkg::sobel_at(window_next, 2'd1, 2'd2, 2'd2,
                                        s1_flags_ff.left_col ? 2'd1 : 2'd0, 2'd1, 2'd2,
                                        1'b0);
      res_last_flush = sbl_pkg::sobel_at(window_next, 2'd1, 2'd2, 2'd2,
                                         2'd1, 2'd2, 2'd2, 1'b1);
   end

   // Pack the released words; the last row always has a row above, so its pair
   // only ever follows the main word.
   always_comb begin
      push.entry[0] = res_main;
      push.entry[1] = s1_flags_ff.row_end ? res_flush : res_last_main;
      push.entry[2] = res_last_main;
      push.entry[3] = res_last_flush;
      if (!(s1_valid_ff && s1_flags_ff.has_result)) begin
         push.count = 3'd0;
      end else begin
         unique case ({s1_flags_ff.row_end, s1_flags_ff.last_row})
            2'b00:   push.count = 3'd1;
            2'b01:   push.count = 3'd2;
            2'b10:   push.count = 3'd2;
            default: push.count = 3'd4;
         endcase
      end
      push.entry[0].last_of_run = (push.count == 3'd1);
      push.entry[1].last_of_run = (push.count == 3'd2);
      push.entry[2].last_of_run = 1'b0;
      push.entry[3].last_of_run = 1'b1;
   end

   // Hold input back unless the queue keeps room for a full run after this push.
   assign req_stall = (int'(queue_level) + int'(push.count)) >
                      (sbl_pkg::QUEUE_DEPTH - sbl_pkg::MAX_RUN);

   sbl_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_pop),
      .head       (head),
      .head_valid (rsp_valid),
      .level      (queue_level)
   );

   assign rsp_pop         = rsp_valid & ~rsp_stall;
   assign rsp_grad_x      = head.grad_x;
   assign rsp_grad_y      = head.grad_y;
   assign rsp_last_of_run = head.last_of_run;
   assign rsp_frame_end   = head.frame_end;

endmodule

`default_nettype wire

### rtl/sbl_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module sbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next enabled read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/sbl_rsp_queue.sv
`default_nettype none

// Result queue: takes up to four words a cycle, gives one word a cycle when popped.
module sbl_rsp_queue (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire sbl_pkg::rsp_push_type        push,
   input  wire logic                         pop,
   output sbl_pkg::rsp_entry_type            head,
   output logic                              head_valid,
   output logic [sbl_pkg::LEVEL_W-1:0]       level
);

   sbl_pkg::rsp_entry_type          slot_ff [sbl_pkg::QUEUE_DEPTH];
   logic [sbl_pkg::PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [sbl_pkg::PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [sbl_pkg::LEVEL_W-1:0]     level_ff, level_in;
   logic [sbl_pkg::PTR_W-1:0]       wr_slot [sbl_pkg::MAX_RUN];

   // Slot addresses for the words pushed this cycle.
   always_comb begin
      for (int k = 0; k < sbl_pkg::MAX_RUN; k++) begin
         wr_slot[k] = wr_ptr_ff + sbl_pkg::PTR_W'(k);
      end
   end

   // Payload storage.
   always_ff @(posedge clock) begin
      for (int k = 0; k < sbl_pkg::MAX_RUN; k++) begin
         if (sbl_pkg::RUN_CNT_W'(k) < push.count) begin
            slot_ff[wr_slot[k]] <= push.entry[k];
         end
      end
   end

   // Pointer and fill level updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + sbl_pkg::PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + sbl_pkg::PTR_W'(pop);
      level_in  = level_ff + sbl_pkg::LEVEL_W'(push.count) - sbl_pkg::LEVEL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   assign head       = slot_ff[rd_ptr_ff];
   assign head_valid = (level_ff != '0);
   assign level      = level_ff;

endmodule

`default_nettype wire
